// File: rtl/core/qoi_pkg.sv
// ----------------------------------------------------------------------------
// qoi_pkg
// Shared constants, types and the header byte table of the QOI encoder.
// ----------------------------------------------------------------------------
package qoi_pkg;

  localparam int DIM_BITS = 16;
  localparam logic [31:0] DIM_MASK = 32'((64'd1 << DIM_BITS) - 64'd1);

  localparam logic [31:0] QOI_MAGIC  = 32'h716F6966;
  localparam logic [31:0] PREV_RESET = 32'h000000FF;
  localparam logic [5:0]  RUN_MAX    = 6'd62;

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hC0;
  localparam logic [7:0] OP_RGB   = 8'hFE;
  localparam logic [7:0] OP_RGBA  = 8'hFF;

  localparam int HDR_LEN = 14;
  localparam int END_LEN = 8;
  localparam int OP_MAX  = 5;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_CHANNELS,
    REG_COLORSPACE
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  channels;
    logic        colorspace;
  } cfg_t;

  typedef struct packed {
    logic                   hdr;
    logic                   run_en;
    logic [7:0]             run_byte;
    logic [2:0]             op_len;
    logic [OP_MAX-1:0][7:0] op_bytes;
    logic                   eoi;
  } cmd_t;

  function automatic logic [7:0] header_byte(input logic [3:0] idx, input cfg_t cfg);
    logic [31:0] w;
    logic [31:0] h;
    logic [7:0]  res;
    w = {16'd0, cfg.width} & DIM_MASK;
    h = {16'd0, cfg.height} & DIM_MASK;
    case (idx)
      4'd0:    res = QOI_MAGIC[31:24];
      4'd1:    res = QOI_MAGIC[23:16];
      4'd2:    res = QOI_MAGIC[15:8];
      4'd3:    res = QOI_MAGIC[7:0];
      4'd4:    res = w[31:24];
      4'd5:    res = w[23:16];
      4'd6:    res = w[15:8];
      4'd7:    res = w[7:0];
      4'd8:    res = h[31:24];
      4'd9:    res = h[23:16];
      4'd10:   res = h[15:8];
      4'd11:   res = h[7:0];
      4'd12:   res = {5'd0, cfg.channels};
      4'd13:   res = {7'd0, cfg.colorspace};
      default: res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/core/qoi_front.sv
// ----------------------------------------------------------------------------
// qoi_front
// Pixel intake and classification: hash stage, colour index RAM, encoder
// state and command build. Emits one command per pixel that yields bytes.
// ----------------------------------------------------------------------------
module qoi_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  logic [7:0]         alpha,
  input  logic               chan4,
  input  logic [31:0]        total,
  input  logic               fifo_full,
  output logic               cmd_push,
  output qoi_pkg::cmd_t      cmd
);

  logic [7:0]  alpha_eff;
  logic [5:0]  in_hash;
  logic        advance;
  logic        accept;
  logic        b_fire;

  logic        a_valid;
  logic [31:0] a_px;
  logic [5:0]  a_hash;

  logic        b_valid;
  logic [31:0] b_px;
  logic [5:0]  b_hash;
  logic [31:0] rdata;

  logic [31:0] mem [64];
  logic [63:0] idx_valid;
  logic        fwd_valid;
  logic [5:0]  fwd_hash;
  logic [31:0] fwd_data;

  logic [31:0] prev;
  logic [5:0]  run;
  logic [31:0] count;

  logic [31:0] entry_raw;
  logic [31:0] entry;
  logic        last;
  logic        first;
  logic        same;
  logic        hit;
  logic        idx_write;
  logic [5:0]  run_inc;
  logic [5:0]  run_next;
  logic        run_flush;
  logic [7:0]  run_byte;
  logic [7:0]  r, g, b, a, pr, pg, pb, pa;
  logic [7:0]  vr, vg, vb, vgr, vgb;
  logic [7:0]  dr, dg, db, lg, lr, lb;
  logic [2:0]  op_len;
  logic [qoi_pkg::OP_MAX-1:0][7:0] op_bytes;

  assign alpha_eff = chan4 ? alpha : 8'hFF;
  assign in_hash = red[5:0] * 6'd3 + green[5:0] * 6'd5 + blue[5:0] * 6'd7
                 + alpha_eff[5:0] * 6'd11;

  assign entry_raw = (fwd_valid && fwd_hash == b_hash) ? fwd_data : rdata;
  assign entry     = idx_valid[b_hash] ? entry_raw : 32'd0;
  assign last      = ({1'b0, count} + 33'd1) >= {1'b0, total};
  assign first     = count == 32'd0;

  assign {r, g, b, a}     = b_px;
  assign {pr, pg, pb, pa} = prev;
  assign same      = b_px == prev;
  assign hit       = entry == b_px;
  assign idx_write = !same && !hit;
  assign run_inc   = run + 6'd1;

  assign vr  = r - pr;
  assign vg  = g - pg;
  assign vb  = b - pb;
  assign vgr = vr - vg;
  assign vgb = vb - vg;
  assign dr  = vr + 8'd2;
  assign dg  = vg + 8'd2;
  assign db  = vb + 8'd2;
  assign lg  = vg + 8'd32;
  assign lr  = vgr + 8'd8;
  assign lb  = vgb + 8'd8;

  always_comb begin
    if (same) begin
      run_flush = (run_inc == qoi_pkg::RUN_MAX) || last;
      run_byte  = qoi_pkg::OP_RUN | {2'b00, run};
      run_next  = run_flush ? 6'd0 : run_inc;
    end else begin
      run_flush = run != 6'd0;
      run_byte  = qoi_pkg::OP_RUN | {2'b00, run - 6'd1};
      run_next  = 6'd0;
    end
  end

  always_comb begin
    op_len   = 3'd0;
    op_bytes = '0;
    if (same) begin
      op_len = 3'd0;
    end else if (hit) begin
      op_len      = 3'd1;
      op_bytes[0] = qoi_pkg::OP_INDEX | {2'b00, b_hash};
    end else if (a == pa) begin
      if (dr < 8'd4 && dg < 8'd4 && db < 8'd4) begin
        op_len      = 3'd1;
        op_bytes[0] = qoi_pkg::OP_DIFF | {2'b00, dr[1:0], dg[1:0], db[1:0]};
      end else if (lr < 8'd16 && lg < 8'd64 && lb < 8'd16) begin
        op_len      = 3'd2;
        op_bytes[0] = qoi_pkg::OP_LUMA | {2'b00, lg[5:0]};
        op_bytes[1] = {lr[3:0], lb[3:0]};
      end else begin
        op_len      = 3'd4;
        op_bytes[0] = qoi_pkg::OP_RGB;
        op_bytes[1] = r;
        op_bytes[2] = g;
        op_bytes[3] = b;
      end
    end else begin
      op_len      = 3'd5;
      op_bytes[0] = qoi_pkg::OP_RGBA;
      op_bytes[1] = r;
      op_bytes[2] = g;
      op_bytes[3] = b;
      op_bytes[4] = a;
    end
  end

  assign cmd.hdr      = first;
  assign cmd.run_en   = run_flush;
  assign cmd.run_byte = run_byte;
  assign cmd.op_len   = op_len;
  assign cmd.op_bytes = op_bytes;
  assign cmd.eoi      = last;

  assign cmd_push    = b_valid && (first || run_flush || op_len != 3'd0 || last) && !fifo_full;
  assign advance     = !(b_valid && (first || run_flush || op_len != 3'd0 || last) && fifo_full);
  assign pixel_stall = !advance;
  assign accept      = pixel_valid && advance;
  assign b_fire      = b_valid && advance;

  always_ff @(posedge clk) begin
    if (b_fire && idx_write) begin
      mem[b_hash] <= b_px;
    end
    if (advance) begin
      rdata <= mem[a_hash];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
      prev      <= qoi_pkg::PREV_RESET;
      run       <= 6'd0;
      count     <= 32'd0;
      idx_valid <= '0;
    end else if (advance) begin
      a_valid   <= accept;
      a_px      <= {red, green, blue, alpha_eff};
      a_hash    <= in_hash;
      b_valid   <= a_valid;
      b_px      <= a_px;
      b_hash    <= a_hash;
      fwd_valid <= b_fire && idx_write;
      fwd_hash  <= b_hash;
      fwd_data  <= b_px;
      if (b_fire) begin
        if (last) begin
          prev      <= qoi_pkg::PREV_RESET;
          run       <= 6'd0;
          count     <= 32'd0;
          idx_valid <= '0;
        end else begin
          prev  <= b_px;
          run   <= run_next;
          count <= count + 32'd1;
          if (idx_write) begin
            idx_valid[b_hash] <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/qoi_cmd_fifo.sv
// ----------------------------------------------------------------------------
// qoi_cmd_fifo
// Short command queue between classification and byte serialisation.
// ----------------------------------------------------------------------------
module qoi_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  qoi_pkg::cmd_t cmd_in,
  output logic          full,
  input  logic          pop,
  output qoi_pkg::cmd_t cmd_out,
  output logic          empty
);

  qoi_pkg::cmd_t entries [qoi_pkg::FIFO_DEPTH];
  logic [qoi_pkg::FIFO_PTR_BITS-1:0] wr_ptr;
  logic [qoi_pkg::FIFO_PTR_BITS-1:0] rd_ptr;
  logic [qoi_pkg::FIFO_PTR_BITS:0]   fill;

  assign full    = fill == (qoi_pkg::FIFO_PTR_BITS+1)'(qoi_pkg::FIFO_DEPTH);
  assign empty   = fill == '0;
  assign cmd_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + (qoi_pkg::FIFO_PTR_BITS)'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + (qoi_pkg::FIFO_PTR_BITS)'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + (qoi_pkg::FIFO_PTR_BITS+1)'(1);
        2'b01:   fill <= fill - (qoi_pkg::FIFO_PTR_BITS+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/core/qoi_back.sv
// ----------------------------------------------------------------------------
// qoi_back
// Byte serialiser: walks header, run, op and end-marker segments of the
// head command and drives the registered byte output.
// ----------------------------------------------------------------------------
module qoi_back (
  input  logic          clk,
  input  logic          rst,
  input  qoi_pkg::cfg_t cfg,
  input  qoi_pkg::cmd_t cmd,
  input  logic          empty,
  output logic          pop,
  output logic          byte_valid,
  input  logic          byte_stall,
  output logic [7:0]    out_byte,
  output logic          pixel_done,
  output logic          image_done
);

  typedef enum logic [1:0] {
    SEG_HDR,
    SEG_RUN,
    SEG_OP,
    SEG_END
  } seg_t;

  seg_t       seg;
  seg_t       init_seg;
  seg_t       cur_seg;
  seg_t       next_seg;
  logic       fresh;
  logic [3:0] cnt;
  logic [3:0] seg_len;
  logic       seg_last;
  logic       has_next;
  logic       load;
  logic [7:0] byte_next;

  always_comb begin
    if (cmd.hdr) begin
      init_seg = SEG_HDR;
    end else if (cmd.run_en) begin
      init_seg = SEG_RUN;
    end else if (cmd.op_len != 3'd0) begin
      init_seg = SEG_OP;
    end else begin
      init_seg = SEG_END;
    end
  end

  assign cur_seg = fresh ? init_seg : seg;

  always_comb begin
    has_next = 1'b0;
    next_seg = SEG_END;
    case (cur_seg)
      SEG_HDR: begin
        if (cmd.run_en) begin
          has_next = 1'b1;
          next_seg = SEG_RUN;
        end else if (cmd.op_len != 3'd0) begin
          has_next = 1'b1;
          next_seg = SEG_OP;
        end else begin
          has_next = cmd.eoi;
        end
      end
      SEG_RUN: begin
        if (cmd.op_len != 3'd0) begin
          has_next = 1'b1;
          next_seg = SEG_OP;
        end else begin
          has_next = cmd.eoi;
        end
      end
      SEG_OP: begin
        has_next = cmd.eoi;
      end
      default: begin
        has_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cur_seg)
      SEG_HDR: begin
        seg_len   = 4'(qoi_pkg::HDR_LEN);
        byte_next = qoi_pkg::header_byte(cnt, cfg);
      end
      SEG_RUN: begin
        seg_len   = 4'd1;
        byte_next = cmd.run_byte;
      end
      SEG_OP: begin
        seg_len   = {1'b0, cmd.op_len};
        byte_next = cmd.op_bytes[cnt[2:0]];
      end
      default: begin
        seg_len   = 4'(qoi_pkg::END_LEN);
        byte_next = (cnt == 4'(qoi_pkg::END_LEN - 1)) ? 8'd1 : 8'd0;
      end
    endcase
  end

  assign seg_last = cnt == seg_len - 4'd1;
  assign load     = !empty && (!byte_valid || !byte_stall);
  assign pop      = load && seg_last && !has_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      fresh      <= 1'b1;
      seg        <= SEG_HDR;
      cnt        <= 4'd0;
    end else if (load) begin
      byte_valid <= 1'b1;
      out_byte   <= byte_next;
      pixel_done <= pop;
      image_done <= seg_last && cur_seg == SEG_END;
      if (seg_last) begin
        cnt   <= 4'd0;
        seg   <= next_seg;
        fresh <= !has_next;
      end else begin
        cnt   <= cnt + 4'd1;
        seg   <= cur_seg;
        fresh <= 1'b0;
      end
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/qoi_image_encoder.sv
// ----------------------------------------------------------------------------
// qoi_image_encoder
// QOI image encoder: pixels in, encoded byte stream out.
// ----------------------------------------------------------------------------
// One pixel is taken per cycle while the four-entry command queue has room;
// a pixel passes a hash stage and a classify stage (colour index RAM read
// registered between them) before its command is queued. The byte side
// emits one byte per cycle while byte_stall is low, so a pixel yields 0 to 28
// output bytes: 14 header bytes on the first pixel, up to 6 code bytes, and 8
// end-marker bytes on the last; sustained pixel rate is set by the output byte port.
// Configuration must be written only while the block is idle; header fields
// come from the live registers.
module qoi_image_encoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_stall,
  input  logic [7:0]                         red,
  input  logic [7:0]                         green,
  input  logic [7:0]                         blue,
  input  logic [7:0]                         alpha,
  output logic                               byte_valid,
  input  logic                               byte_stall,
  output logic [7:0]                         out_byte,
  output logic                               pixel_done,
  output logic                               image_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qoi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [qoi_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  qoi_pkg::cfg_t cfg;
  qoi_pkg::cmd_t push_cmd;
  qoi_pkg::cmd_t head_cmd;
  logic [31:0]   total;
  logic          fifo_full;
  logic          fifo_empty;
  logic          cmd_push;
  logic          cmd_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width      <= 16'd1;
      cfg.height     <= 16'd1;
      cfg.channels   <= 3'd4;
      cfg.colorspace <= 1'b0;
      total          <= 32'd1;
    end else begin
      total <= 32'(cfg.width) * 32'(cfg.height);
      if (cfg_valid && cfg_ready) begin
        case (qoi_pkg::cfg_reg_t'(cfg_index))
          qoi_pkg::REG_WIDTH:      cfg.width      <= cfg_data[15:0];
          qoi_pkg::REG_HEIGHT:     cfg.height     <= cfg_data[15:0];
          qoi_pkg::REG_CHANNELS:   cfg.channels   <= cfg_data[2:0];
          qoi_pkg::REG_COLORSPACE: cfg.colorspace <= cfg_data[0];
          default:                 cfg.width      <= cfg.width;
        endcase
      end
    end
  end

  qoi_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .chan4       (cfg.channels == 3'd4),
    .total       (total),
    .fifo_full   (fifo_full),
    .cmd_push    (cmd_push),
    .cmd         (push_cmd)
  );

  qoi_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .cmd_in  (push_cmd),
    .full    (fifo_full),
    .pop     (cmd_pop),
    .cmd_out (head_cmd),
    .empty   (fifo_empty)
  );

  qoi_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (head_cmd),
    .empty      (fifo_empty),
    .pop        (cmd_pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_byte   (out_byte),
    .pixel_done (pixel_done),
    .image_done (image_done)
  );

endmodule

// File: rtl/core/qoi_checker.sv
// ----------------------------------------------------------------------------
// qoi_checker
// Port-level checks on the encoder output stream, bound to the top level.
// ----------------------------------------------------------------------------
module qoi_checker (
  input logic       clk,
  input logic       rst,
  input logic       byte_valid,
  input logic       byte_stall,
  input logic [7:0] out_byte,
  input logic       pixel_done,
  input logic       image_done
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(out_byte)
                                 && $stable(pixel_done) && $stable(image_done))
    else $error("stalled output transfer changed");

  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    byte_valid && image_done |-> pixel_done && out_byte == 8'h01)
    else $error("image end not on end-marker byte closing a pixel");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !byte_valid)
    else $error("output valid straight after reset");

endmodule

bind qoi_image_encoder qoi_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .out_byte   (out_byte),
  .pixel_done (pixel_done),
  .image_done (image_done)
);
